/* design/btlv_pkg.sv */
// Shared types and constants for the streaming tag-length-value parser.
// Used by btlv_parser and ber_tlv_stream_parser_core.
`default_nettype none

package btlv_pkg;

	localparam int MAX_NEST_DEF     = 8;
	localparam int MSG_LEN_BITS_DEF = 16;

	localparam logic [4:0] TAG_MULTI_MASK = 5'h1F;
	localparam int         MAX_TAG_BYTES  = 4;
	localparam int         MAX_LEN_BYTES  = 4;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_TAG_FIRST = 3'd1,
		PH_TAG_MORE  = 3'd2,
		PH_LEN_FIRST = 3'd3,
		PH_LEN_MORE  = 3'd4,
		PH_DATA      = 3'd5,
		PH_DONE      = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_TAG_LONG   = 3'd1,
		ERR_LEN_FIELD  = 3'd2,
		ERR_LEN_EXCEED = 3'd3,
		ERR_TRUNCATED  = 3'd4,
		ERR_TOO_DEEP   = 3'd5
	} err_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] tag;
		logic [15:0] length;
		logic [3:0]  elem_depth;
		logic        constructed;
		logic [7:0]  value_byte;
		err_t        error_code;
		logic        message_end;
	} result_t;

endpackage

`default_nettype wire

/* design/ber_tlv_stream_parser_core.sv */
// Top level: input register, parser, result register and the base-depth register.
// Depends on btlv_pkg and btlv_parser.
//
// Usage: message bytes enter on the s_ stream, one per item. s_tuser marks the
// first byte of a message; s_tdata carries that byte and the message length,
// which is sampled with the first byte. Each byte gives zero or one result on
// the m_ stream: an element header, a primitive data byte or an error, told
// apart by m_tuser. m_tlast marks the result that completes the message.
// base_depth is to be written through cfg_wr_en / cfg_wr_data only while the block
// idles; the block does not enforce this. Each byte goes from the input register
// through the parser to the result register. Throughput: one byte per cycle while
// results are taken; the parse state loops back through a single stage of decode
// logic with one compare per nesting level. Reset clears the parser to idle,
// awaiting a message start, and empties both registers; bytes before the first
// message start give no result. When the receiver stalls, the result register holds,
// the input register fills and s_tready drops until the result is taken.
`default_nettype none

module ber_tlv_stream_parser_core #(
	parameter int MAX_NEST     = btlv_pkg::MAX_NEST_DEF,
	parameter int MSG_LEN_BITS = btlv_pkg::MSG_LEN_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,     // data_byte[7:0], message_length[23:8]
	input  wire logic        s_tuser,     // message_start
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [63:0] m_tdata,     // tag[31:0], length[47:32], elem_depth[51:48],
	                                      // constructed[52], value_byte[60:53],
	                                      // error_code[63:61]
	output logic      [1:0]  m_tuser,     // kind
	output logic             m_tlast,     // message_end
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_wr_data  // base_depth
);

	logic              valid_s1;
	logic [23:0]       data_s1;
	logic              start_s1;
	logic              advance;
	logic              res_valid;
	btlv_pkg::result_t res;
	logic              valid_s2;
	btlv_pkg::result_t res_s2;
	logic [2:0]        base_depth_q;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_depth_q <= '0;
		end else if (cfg_wr_en) begin
			base_depth_q <= cfg_wr_data;
		end
	end

	btlv_parser #(
		.MAX_NEST     (MAX_NEST),
		.MSG_LEN_BITS (MSG_LEN_BITS)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (advance),
		.data_byte      (data_s1[7:0]),
		.message_start  (start_s1),
		.message_length (data_s1[23:8]),
		.base_depth     (base_depth_q),
		.res_valid      (res_valid),
		.res            (res)
	);

	// Load on advance; otherwise drop the held item once it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.kind;
	assign m_tlast  = res_s2.message_end;
	assign m_tdata  = {res_s2.error_code, res_s2.value_byte, res_s2.constructed,
	                   res_s2.elem_depth, res_s2.length, res_s2.tag};

endmodule

`default_nettype wire

/* design/btlv_end_stack.sv */
// End-offset stack of the open constructed elements, with one compare per level.
// Depends on nothing but its parameters.
`default_nettype none

module btlv_end_stack #(
	parameter int MAX_NEST     = 8,
	parameter int MSG_LEN_BITS = 16,
	localparam int NW = $clog2(MAX_NEST + 1),
	localparam int IW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    push_en,
	input  wire logic [MSG_LEN_BITS-1:0] push_end,
	input  wire logic [NW-1:0]           cur_nest,
	input  wire logic [MSG_LEN_BITS-1:0] probe_pos,
	output logic      [MSG_LEN_BITS-1:0] top_end,
	output logic      [NW-1:0]           keep_nest
);

	logic [MSG_LEN_BITS-1:0] ends_q [MAX_NEST];
	logic [NW-1:0]           top_lvl;

	always_ff @(posedge clk) begin
		if (push_en) begin
			ends_q[cur_nest[IW-1:0]] <= push_end;
		end
	end

	assign top_lvl = cur_nest - NW'(1);
	assign top_end = ends_q[top_lvl[IW-1:0]];

	// Ends nest inward, so the levels still open form a prefix of the stack.
	always_comb begin
		keep_nest = '0;
		for (int i = 0; i < MAX_NEST; i++) begin
			if ((NW'(i) < cur_nest) && (ends_q[i] > probe_pos)) begin
				keep_nest = NW'(i + 1);
			end
		end
	end

endmodule

`default_nettype wire

/* design/btlv_parser.sv */
// Parser state and per-byte decode: tag, length, data and nesting control.
// Depends on btlv_pkg and btlv_end_stack.
`default_nettype none

module btlv_parser #(
	parameter int MAX_NEST     = btlv_pkg::MAX_NEST_DEF,
	parameter int MSG_LEN_BITS = btlv_pkg::MSG_LEN_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic [7:0]       data_byte,
	input  wire logic             message_start,
	input  wire logic [15:0]      message_length,
	input  wire logic [2:0]       base_depth,
	output logic                  res_valid,
	output btlv_pkg::result_t     res
);

	localparam int NW = $clog2(MAX_NEST + 1);
	localparam int B  = MSG_LEN_BITS;

	btlv_pkg::phase_t phase_q, cur_phase, phase_d;
	logic [B-1:0]  pos_q, cur_pos, pos_d;
	logic [B-1:0]  end_q, cur_end;
	logic [NW-1:0] nest_q, cur_nest, nest_d;
	logic [31:0]   tag_q, cur_tag, tag_d;
	logic [2:0]    tcnt_q, cur_tcnt, tcnt_d;
	logic [31:0]   lacc_q, cur_lacc, lacc_d;
	logic [2:0]    lbl_q, cur_lbl, lbl_d;
	logic [B-1:0]  dbl_q, cur_dbl, dbl_d;
	logic          cflag_q, cur_cflag, cflag_d;

	logic          start;
	logic          live, work;
	logic [B-1:0]  nxt, encl, room, top_end, dbl_new, push_end;
	logic [NW-1:0] keep_nest;
	logic [31:0]   tag_new, lacc_new, hdr_len;
	logic [2:0]    tcnt_new;
	logic          hdr_end, too_long, too_deep, trunc, msg_over;
	logic          push, close_now;
	logic [3:0]    cur_depth;
	btlv_pkg::err_t err_code;
	logic          err;

	// A message start restarts the parser before the byte is looked at.
	assign start     = en && message_start;
	assign cur_phase = start ? btlv_pkg::PH_TAG_FIRST : phase_q;
	assign cur_pos   = start ? '0 : pos_q;
	assign cur_end   = start ? B'(message_length) : end_q;
	assign cur_nest  = start ? '0 : nest_q;
	assign cur_tag   = start ? '0 : tag_q;
	assign cur_tcnt  = start ? '0 : tcnt_q;
	assign cur_lacc  = start ? '0 : lacc_q;
	assign cur_lbl   = start ? '0 : lbl_q;
	assign cur_dbl   = start ? '0 : dbl_q;
	assign cur_cflag = start ? 1'b0 : cflag_q;

	assign live = (cur_phase != btlv_pkg::PH_IDLE) && (cur_phase != btlv_pkg::PH_DONE);
	assign work = en && live && (cur_pos < cur_end);

	assign nxt       = cur_pos + B'(1);
	assign encl      = (cur_nest != '0) ? top_end : cur_end;
	assign room      = (encl > nxt) ? (encl - nxt) : '0;
	assign trunc     = (nxt >= encl);
	assign msg_over  = (nxt >= cur_end);
	assign cur_depth = 4'(base_depth) + 4'(cur_nest);
	assign tag_new   = (cur_phase == btlv_pkg::PH_TAG_FIRST) ? {24'd0, data_byte}
	                                                         : {cur_tag[23:0], data_byte};
	assign tcnt_new  = cur_tcnt + 3'd1;
	assign lacc_new  = {cur_lacc[23:0], data_byte};
	assign dbl_new   = (cur_dbl != '0) ? (cur_dbl - B'(1)) : cur_dbl;
	assign hdr_len   = (cur_phase == btlv_pkg::PH_LEN_MORE) ? lacc_new
	                 : (data_byte[7] ? 32'd0 : {24'd0, data_byte});
	assign too_long  = (hdr_len > 32'(room));
	assign too_deep  = cur_cflag && (hdr_len != '0) && (32'(cur_nest) >= 32'(MAX_NEST));
	assign push_end  = nxt + B'(hdr_len);

	// Decode: where the header ends and which error this byte raises.
	always_comb begin
		hdr_end  = 1'b0;
		err_code = btlv_pkg::ERR_NONE;
		unique case (cur_phase)
			btlv_pkg::PH_TAG_FIRST: begin
				if (trunc) err_code = btlv_pkg::ERR_TRUNCATED;
			end
			btlv_pkg::PH_TAG_MORE: begin
				if (data_byte[7] && (32'(tcnt_new) >= 32'(btlv_pkg::MAX_TAG_BYTES))) begin
					err_code = btlv_pkg::ERR_TAG_LONG;
				end else if (trunc) begin
					err_code = btlv_pkg::ERR_TRUNCATED;
				end
			end
			btlv_pkg::PH_LEN_FIRST: begin
				if (!data_byte[7] || (data_byte[6:0] == 7'd0)) begin
					hdr_end = 1'b1;
				end else if (32'(data_byte[6:0]) > 32'(btlv_pkg::MAX_LEN_BYTES)) begin
					err_code = btlv_pkg::ERR_LEN_FIELD;
				end else if (trunc) begin
					err_code = btlv_pkg::ERR_TRUNCATED;
				end
			end
			btlv_pkg::PH_LEN_MORE: begin
				if (cur_lbl == 3'd1) begin
					hdr_end = 1'b1;
				end else if (trunc) begin
					err_code = btlv_pkg::ERR_TRUNCATED;
				end
			end
			default: ;
		endcase
		if (hdr_end) begin
			if (too_long) begin
				err_code = btlv_pkg::ERR_LEN_EXCEED;
			end else if (too_deep) begin
				err_code = btlv_pkg::ERR_TOO_DEEP;
			end
		end
	end

	assign err       = (err_code != btlv_pkg::ERR_NONE);
	assign push      = work && hdr_end && !err && cur_cflag && (hdr_len != '0);
	assign close_now = work && !err && ((hdr_end && (hdr_len == '0)) ||
	                   ((cur_phase == btlv_pkg::PH_DATA) && (dbl_new == '0)));

	btlv_end_stack #(
		.MAX_NEST     (MAX_NEST),
		.MSG_LEN_BITS (MSG_LEN_BITS)
	) u_stack (
		.clk       (clk),
		.push_en   (push),
		.push_end  (push_end),
		.cur_nest  (cur_nest),
		.probe_pos (nxt),
		.top_end   (top_end),
		.keep_nest (keep_nest)
	);

	// Next state.
	always_comb begin
		phase_d = cur_phase;
		pos_d   = cur_pos;
		nest_d  = cur_nest;
		tag_d   = cur_tag;
		tcnt_d  = cur_tcnt;
		lacc_d  = cur_lacc;
		lbl_d   = cur_lbl;
		dbl_d   = cur_dbl;
		cflag_d = cur_cflag;
		if (work) begin
			pos_d = nxt;
			if (err) begin
				phase_d = btlv_pkg::PH_DONE;
			end else begin
				unique case (cur_phase)
					btlv_pkg::PH_TAG_FIRST: begin
						tag_d   = tag_new;
						tcnt_d  = 3'd1;
						cflag_d = data_byte[5];
						phase_d = (data_byte[4:0] == btlv_pkg::TAG_MULTI_MASK)
						        ? btlv_pkg::PH_TAG_MORE : btlv_pkg::PH_LEN_FIRST;
					end
					btlv_pkg::PH_TAG_MORE: begin
						tag_d  = tag_new;
						tcnt_d = tcnt_new;
						if (!data_byte[7]) phase_d = btlv_pkg::PH_LEN_FIRST;
					end
					btlv_pkg::PH_LEN_FIRST: begin
						if (!hdr_end) begin
							lbl_d   = data_byte[2:0];
							lacc_d  = '0;
							phase_d = btlv_pkg::PH_LEN_MORE;
						end
					end
					btlv_pkg::PH_LEN_MORE: begin
						lacc_d = lacc_new;
						lbl_d  = cur_lbl - 3'd1;
					end
					btlv_pkg::PH_DATA: begin
						dbl_d = dbl_new;
					end
					default: phase_d = btlv_pkg::PH_DONE;
				endcase
				if (push) begin
					nest_d  = cur_nest + NW'(1);
					phase_d = btlv_pkg::PH_TAG_FIRST;
				end else if (hdr_end && (hdr_len != '0)) begin
					dbl_d   = B'(hdr_len);
					phase_d = btlv_pkg::PH_DATA;
				end
				if (close_now) begin
					nest_d  = keep_nest;
					phase_d = msg_over ? btlv_pkg::PH_DONE : btlv_pkg::PH_TAG_FIRST;
				end
			end
		end else if (en && live) begin
			phase_d = btlv_pkg::PH_DONE;
		end
	end

	// Result.
	always_comb begin
		res       = '0;
		res_valid = work && (err || hdr_end || (cur_phase == btlv_pkg::PH_DATA));
		if (err) begin
			res.kind       = btlv_pkg::KIND_ERROR;
			res.error_code = err_code;
		end else if (hdr_end) begin
			res.kind        = btlv_pkg::KIND_HEADER;
			res.tag         = cur_tag;
			res.length      = hdr_len[15:0];
			res.elem_depth  = cur_depth;
			res.constructed = cur_cflag;
			res.message_end = close_now && msg_over;
		end else if (cur_phase == btlv_pkg::PH_DATA) begin
			res.kind        = btlv_pkg::KIND_DATA;
			res.elem_depth  = cur_depth;
			res.value_byte  = data_byte;
			res.message_end = close_now && msg_over;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= btlv_pkg::PH_IDLE;
			pos_q   <= '0;
			end_q   <= '0;
			nest_q  <= '0;
			tag_q   <= '0;
			tcnt_q  <= '0;
			lacc_q  <= '0;
			lbl_q   <= '0;
			dbl_q   <= '0;
			cflag_q <= 1'b0;
		end else if (en) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			end_q   <= cur_end;
			nest_q  <= nest_d;
			tag_q   <= tag_d;
			tcnt_q  <= tcnt_d;
			lacc_q  <= lacc_d;
			lbl_q   <= lbl_d;
			dbl_q   <= dbl_d;
			cflag_q <= cflag_d;
		end
	end

endmodule

`default_nettype wire
